[src/spct_pkg.sv]
// spct_pkg: shared types and constants for the symmetric pair cache table
// operation codes, sequencer states, compare result struct, fill word
// no dependencies
package spct_pkg;

  localparam int WORD_W                = 32;
  localparam int DEFAULT_TABLE_ENTRIES = 64;

  localparam logic [1:0] FUNC_GET   = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [WORD_W-1:0] FILL_WORD = {WORD_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  // outcome of comparing one stored pair against the requested pair
  typedef struct packed {
    logic hit;
    logic swapped;
  } match_t;

endpackage

[src/spct_pair_cmp.sv]
// spct_pair_cmp: shared pair compare unit of the symmetric pair cache table
// checks one stored key against the requested pair in both orders
// depends on spct_pkg
module spct_pair_cmp (
  input  logic [2*spct_pkg::WORD_W-1:0] key,
  input  logic [spct_pkg::WORD_W-1:0]   id_a,
  input  logic [spct_pkg::WORD_W-1:0]   id_b,
  output spct_pkg::match_t              match
);

  logic direct;
  logic reverse;

  assign direct  = (key[spct_pkg::WORD_W-1:0] == id_a) &&
                   (key[2*spct_pkg::WORD_W-1:spct_pkg::WORD_W] == id_b);
  assign reverse = (key[spct_pkg::WORD_W-1:0] == id_b) &&
                   (key[2*spct_pkg::WORD_W-1:spct_pkg::WORD_W] == id_a);

  // the stored order wins, so a pair of equal ids is never swapped
  assign match.hit     = direct || reverse;
  assign match.swapped = !direct && reverse;

endmodule

[src/symmetric_pair_cache_table_top.sv]
// symmetric_pair_cache_table_top: table of unordered id pairs with four words each
// key and word memories, scan sequencer, output register
// depends on spct_pkg and spct_pair_cmp

// A get or set item is looked up by a linear scan of the stored pairs in insertion
// order, one key compared per cycle through the single read port of the key memory;
// the block takes no new item until the result has been taken. A hit ends the scan at
// its entry and a miss scans every stored entry. A get miss appends the pair with all
// words at -1 and a set miss appends it with its given words, unless the table already
// holds TABLE_ENTRIES pairs, in which case nothing is written and table_full is set. A pair
// found in swapped order trades words 0-1 with 2-3 on both get and set.
module symmetric_pair_cache_table_top #(
  parameter int TABLE_ENTRIES = spct_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [31:0] first_id,
  input  logic signed [31:0] second_id,
  input  logic signed [31:0] in_word0,
  input  logic signed [31:0] in_word1,
  input  logic signed [31:0] in_word2,
  input  logic signed [31:0] in_word3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_word0,
  output logic signed [31:0] out_word1,
  output logic signed [31:0] out_word2,
  output logic signed [31:0] out_word3,
  output logic               was_present,
  output logic               table_full
);

  localparam int W  = spct_pkg::WORD_W;
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  spct_pkg::state_t state;
  spct_pkg::state_t state_next;

  logic [2*W-1:0] keys  [TABLE_ENTRIES];
  logic [4*W-1:0] words [TABLE_ENTRIES];

  logic [1:0]     func_q;
  logic [W-1:0]   id_a;
  logic [W-1:0]   id_b;
  logic [4*W-1:0] w_in;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  scan_idx;
  logic [CW-1:0]  cmp_idx;
  logic           cmp_live;
  logic [2*W-1:0] key_q;
  logic [4*W-1:0] words_q;

  spct_pkg::match_t match;
  logic             at_end;
  logic             hit;
  logic             is_get;
  logic             is_lookup;

  logic           key_we;
  logic           word_we;
  logic [IW-1:0]  wr_addr;
  logic [4*W-1:0] wr_words;
  logic           load_res;
  logic [4*W-1:0] res_words;
  logic           res_present;
  logic           res_full;

  spct_pair_cmp u_cmp (
    .key   (key_q),
    .id_a  (id_a),
    .id_b  (id_b),
    .match (match)
  );

  assign is_get    = (func_q == spct_pkg::FUNC_GET);
  assign is_lookup = (func == spct_pkg::FUNC_GET) || (func == spct_pkg::FUNC_SET);
  // compare stage has run past the last stored entry
  assign at_end    = cmp_live && (cmp_idx == count);
  assign hit       = cmp_live && !at_end && match.hit;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      spct_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = is_lookup ? spct_pkg::ST_SCAN : spct_pkg::ST_RESP;
        end
      end
      spct_pkg::ST_SCAN: begin
        if (hit || at_end) begin
          state_next = spct_pkg::ST_RESP;
        end
      end
      spct_pkg::ST_RESP: begin
        if (out_ready) begin
          state_next = spct_pkg::ST_IDLE;
        end
      end
      default: state_next = spct_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    key_we      = 1'b0;
    word_we     = 1'b0;
    wr_addr     = cmp_idx[IW-1:0];
    wr_words    = w_in;
    count_next  = count;
    load_res    = 1'b0;
    res_words   = '0;
    res_present = 1'b0;
    res_full    = 1'b0;
    case (state)
      spct_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !is_lookup) begin
          load_res = 1'b1;
          if (func == spct_pkg::FUNC_CLEAR) begin
            count_next = '0;
          end
        end
      end
      spct_pkg::ST_SCAN: begin
        if (hit) begin
          load_res    = 1'b1;
          res_present = 1'b1;
          if (is_get) begin
            res_words = match.swapped ? {words_q[2*W-1:0], words_q[4*W-1:2*W]} : words_q;
          end else begin
            word_we  = 1'b1;
            wr_words = match.swapped ? {w_in[2*W-1:0], w_in[4*W-1:2*W]} : w_in;
          end
        end else if (at_end) begin
          load_res  = 1'b1;
          res_words = is_get ? {4{spct_pkg::FILL_WORD}} : '0;
          if (count == FULL_COUNT) begin
            res_full = 1'b1;
          end else begin
            key_we     = 1'b1;
            word_we    = 1'b1;
            wr_addr    = count[IW-1:0];
            wr_words   = is_get ? {4{spct_pkg::FILL_WORD}} : w_in;
            count_next = count + CW'(1);
          end
        end
      end
      spct_pkg::ST_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= spct_pkg::ST_IDLE;
      count    <= '0;
      cmp_live <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cmp_live <= (state == spct_pkg::ST_SCAN);
    end
  end

  // item capture, scan pointers and result register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func_q   <= func;
      id_a     <= first_id;
      id_b     <= second_id;
      w_in     <= {in_word3, in_word2, in_word1, in_word0};
      scan_idx <= '0;
    end else if (state == spct_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + CW'(1);
    end
    cmp_idx <= scan_idx;
    if (load_res) begin
      out_word0   <= res_words[W-1:0];
      out_word1   <= res_words[2*W-1:W];
      out_word2   <= res_words[3*W-1:2*W];
      out_word3   <= res_words[4*W-1:3*W];
      was_present <= res_present;
      table_full  <= res_full;
    end
  end

  // key and word memories, read data registered
  always_ff @(posedge clk) begin
    if (key_we) begin
      keys[wr_addr] <= {id_b, id_a};
    end
    if (word_we) begin
      words[wr_addr] <= wr_words;
    end
    key_q   <= keys[scan_idx[IW-1:0]];
    words_q <= words[scan_idx[IW-1:0]];
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above table size");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == spct_pkg::ST_SCAN && cmp_live) |-> (cmp_idx <= count))
    else $error("compare stage beyond stored entries");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == spct_pkg::FUNC_CLEAR) |=> (count == '0))
    else $error("clear item left entries");

  a_full_not_present: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(table_full && was_present))
    else $error("result both present and full");

  a_miss_appends: assert property (@(posedge clk) disable iff (rst)
    (state == spct_pkg::ST_SCAN && at_end && !hit && count != FULL_COUNT)
      |=> (count == $past(count) + CW'(1)))
    else $error("miss did not append entry");
`endif

endmodule

[tb/sv/spct_pair_table_checker.sv]
// spct_pair_table_checker: watches both channels of the pair cache table, keeps its own
// copy of the table, predicts every result and compares it field by field
// depends on spct_pkg
`timescale 1ns / 100ps

module spct_pair_table_checker #(
  parameter int TABLE_ENTRIES = spct_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [31:0] first_id,
  input  logic signed [31:0] second_id,
  input  logic signed [31:0] in_word0,
  input  logic signed [31:0] in_word1,
  input  logic signed [31:0] in_word2,
  input  logic signed [31:0] in_word3,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_word0,
  input  logic signed [31:0] out_word1,
  input  logic signed [31:0] out_word2,
  input  logic signed [31:0] out_word3,
  input  logic               was_present,
  input  logic               table_full,
  output int                 mismatch_count,
  output int                 replies_outstanding
);

  typedef struct packed {
    logic [3:0][31:0] words;
    logic             present;
    logic             full;
  } pair_reply_t;

  logic [31:0]      key_first [TABLE_ENTRIES];
  logic [31:0]      key_second[TABLE_ENTRIES];
  logic [3:0][31:0] cached_words[TABLE_ENTRIES];
  int               stored_pairs;
  pair_reply_t      pending_replies[$];
  int               replies_seen;

  initial begin
    mismatch_count      = 0;
    replies_outstanding = 0;
    stored_pairs        = 0;
    replies_seen        = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d: %s got %h expected %h", $time, replies_seen, what, got,
             want);
    mismatch_count++;
  endtask

  // applies one item to the shadow table and returns the reply it must produce
  function automatic pair_reply_t lookup_pair(input logic [1:0] op, input logic [31:0] a,
                                              input logic [31:0] b,
                                              input logic [3:0][31:0] wr_words);
    pair_reply_t reply;
    logic        hit;
    logic        swapped;
    int          pos;
    reply   = '0;
    hit     = 1'b0;
    swapped = 1'b0;
    pos     = 0;
    if (op == spct_pkg::FUNC_CLEAR) begin
      stored_pairs = 0;
      return reply;
    end
    if (op != spct_pkg::FUNC_GET && op != spct_pkg::FUNC_SET) return reply;
    // insertion order, straight order checked before swapped at each entry
    for (int i = 0; i < stored_pairs; i++) begin
      if (!hit) begin
        if (key_first[i] == a && key_second[i] == b) begin
          hit = 1'b1;
          pos = i;
        end else if (key_first[i] == b && key_second[i] == a) begin
          hit     = 1'b1;
          swapped = 1'b1;
          pos     = i;
        end
      end
    end
    if (!hit) begin
      if (stored_pairs >= TABLE_ENTRIES) begin
        reply.full = 1'b1;
        if (op == spct_pkg::FUNC_GET) reply.words = {4{spct_pkg::FILL_WORD}};
        return reply;
      end
      pos               = stored_pairs;
      key_first[pos]    = a;
      key_second[pos]   = b;
      cached_words[pos] = {4{spct_pkg::FILL_WORD}};
      stored_pairs++;
    end else begin
      reply.present = 1'b1;
    end
    if (op == spct_pkg::FUNC_GET) begin
      if (swapped) begin
        reply.words = {cached_words[pos][1], cached_words[pos][0],
                       cached_words[pos][3], cached_words[pos][2]};
      end else begin
        reply.words = cached_words[pos];
      end
    end else begin
      if (swapped) begin
        cached_words[pos] = {wr_words[1], wr_words[0], wr_words[3], wr_words[2]};
      end else begin
        cached_words[pos] = wr_words;
      end
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    pair_reply_t      want;
    pair_reply_t      next_reply;
    logic [3:0][31:0] got_words;
    if (rst) begin
      stored_pairs = 0;
      pending_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (pending_replies.size() == 0) begin
          report_mismatch("result with nothing outstanding, word0", out_word0, '0);
        end else begin
          want      = pending_replies.pop_front();
          got_words = {out_word3, out_word2, out_word1, out_word0};
          for (int k = 0; k < 4; k++) begin
            if (got_words[k] !== want.words[k])
              report_mismatch($sformatf("out_word%0d", k), got_words[k], want.words[k]);
          end
          if (was_present !== want.present)
            report_mismatch("was_present", 32'(was_present), 32'(want.present));
          if (table_full !== want.full)
            report_mismatch("table_full", 32'(table_full), 32'(want.full));
        end
      end
      if (in_valid && in_ready) begin
        next_reply      = lookup_pair(func, first_id, second_id,
                                      {in_word3, in_word2, in_word1, in_word0});
        pending_replies = {pending_replies, next_reply};
      end
    end
    replies_outstanding = pending_replies.size();
  end

endmodule

[tb/sv/symmetric_pair_cache_table_top_tb.sv]
// symmetric_pair_cache_table_top_tb: stimulus, clock, reset and verdict for the pair table
// drives directed then random get/set/clear items; checking lives in spct_pair_table_checker
// depends on spct_pkg, symmetric_pair_cache_table_top, spct_pair_table_checker
`timescale 1ns / 100ps

module symmetric_pair_cache_table_top_tb;

  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [31:0] ID_MIN      = 32'h8000_0000;
  localparam logic [31:0] ID_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
  localparam int          ITEM_TARGET = 1600;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES = 80;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         func      = spct_pkg::FUNC_GET;
  logic signed [31:0] first_id  = '0;
  logic signed [31:0] second_id = '0;
  logic signed [31:0] in_word0  = '0;
  logic signed [31:0] in_word1  = '0;
  logic signed [31:0] in_word2  = '0;
  logic signed [31:0] in_word3  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_word0;
  logic signed [31:0] out_word1;
  logic signed [31:0] out_word2;
  logic signed [31:0] out_word3;
  logic               was_present;
  logic               table_full;

  int mismatch_count;
  int replies_outstanding;
  int items_sent     = 0;
  int send_gap_pct   = 25;
  int recv_stall_pct = 71;
  bit hold_req       = 1'b0;
  bit hold_done      = 1'b0;

  symmetric_pair_cache_table_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .first_id   (first_id),
    .second_id  (second_id),
    .in_word0   (in_word0),
    .in_word1   (in_word1),
    .in_word2   (in_word2),
    .in_word3   (in_word3),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word0  (out_word0),
    .out_word1  (out_word1),
    .out_word2  (out_word2),
    .out_word3  (out_word3),
    .was_present(was_present),
    .table_full (table_full)
  );

  spct_pair_table_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .func               (func),
    .first_id           (first_id),
    .second_id          (second_id),
    .in_word0           (in_word0),
    .in_word1           (in_word1),
    .in_word2           (in_word2),
    .in_word3           (in_word3),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_word0          (out_word0),
    .out_word1          (out_word1),
    .out_word2          (out_word2),
    .out_word3          (out_word3),
    .was_present        (was_present),
    .table_full         (table_full),
    .mismatch_count     (mismatch_count),
    .replies_outstanding(replies_outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // timeout is several times the worst case of block time plus stalls for every item
  initial begin
    #20_000_000;
    $display("** symmetric_pair_cache_table_top: FAILED **");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up into its input
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] pick_id();
    case ($urandom_range(15))
      0:       return ID_MIN;
      1:       return ID_MAX;
      2:       return '0;
      3:       return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_item(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] w0, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] w3);
    // idle mix by thirds of the run: sender light / receiver heavy, swapped, then none
    if (items_sent < ITEM_TARGET / 3) begin
      send_gap_pct   = 25;
      recv_stall_pct = 71;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_gap_pct   = 71;
      recv_stall_pct = 25;
    end else begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
    if (items_sent == 200) hold_req = 1'b1;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid  <= 1'b1;
    func      <= op;
    first_id  <= a;
    second_id <= b;
    in_word0  <= w0;
    in_word1  <= w1;
    in_word2  <= w2;
    in_word3  <= w3;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  initial begin
    logic [31:0] id_pool[10];
    logic [31:0] fill_first[$];
    logic [31:0] fill_second[$];
    logic [31:0] a;
    logic [31:0] b;
    logic [1:0]  op;
    int          kind;
    int          pool_size;
    int          burst_len;
    int          pick;
    bit          fill_next;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: miss append, straight and swapped access, equal ids, extreme ids and words
    offer_item(spct_pkg::FUNC_GET, 5, 9, $urandom, $urandom, $urandom, $urandom);
    offer_item(spct_pkg::FUNC_SET, 5, 9, ID_MIN, ID_MAX, '0, ALL_ONES);
    offer_item(spct_pkg::FUNC_GET, 9, 5, $urandom, $urandom, $urandom, $urandom);
    offer_item(spct_pkg::FUNC_SET, 9, 5, 1, 2, 3, 4);
    offer_item(spct_pkg::FUNC_GET, 5, 9, '0, '0, '0, '0);
    offer_item(spct_pkg::FUNC_GET, 7, 7, '0, '0, '0, '0);
    offer_item(spct_pkg::FUNC_SET, 7, 7, ID_MAX, ID_MIN, ALL_ONES, '0);
    offer_item(spct_pkg::FUNC_GET, 7, 7, '0, '0, '0, '0);
    offer_item(spct_pkg::FUNC_SET, ID_MIN, ID_MAX, $urandom, $urandom, $urandom, $urandom);
    offer_item(spct_pkg::FUNC_GET, ID_MAX, ID_MIN, '0, '0, '0, '0);
    offer_item(spct_pkg::FUNC_GET, '0, ALL_ONES, '0, '0, '0, '0);
    offer_item(spct_pkg::FUNC_SET, ALL_ONES, '0, $urandom, $urandom, $urandom, $urandom);
    offer_item(spct_pkg::FUNC_GET, '0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    offer_item(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    offer_item(spct_pkg::FUNC_GET, 5, 9, '0, '0, '0, '0);
    offer_item(spct_pkg::FUNC_CLEAR, 5, 9, $urandom, $urandom, $urandom, $urandom);
    offer_item(spct_pkg::FUNC_GET, 5, 9, '0, '0, '0, '0);
    offer_item(spct_pkg::FUNC_GET, 9, 5, '0, '0, '0, '0);

    // random: the first sequence is always a fresh-pair run so full-table misses can come early
    fill_next = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      kind      = fill_next ? 70 : $urandom_range(99);
      fill_next = 1'b0;
      if (kind < 8) begin
        offer_item(spct_pkg::FUNC_CLEAR, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 60) begin
        // small id pool: many repeat hits in both orders, equal ids now and then
        pool_size = $urandom_range(10, 3);
        for (int i = 0; i < pool_size; i++) id_pool[i] = pick_id();
        burst_len = $urandom_range(40, 15);
        for (int n = 0; n < burst_len; n++) begin
          pick = $urandom_range(99);
          op   = (pick < 2)  ? FUNC_UNUSED :
                 (pick < 52) ? spct_pkg::FUNC_GET : spct_pkg::FUNC_SET;
          offer_item(op, id_pool[$urandom_range(pool_size - 1)],
                     id_pool[$urandom_range(pool_size - 1)],
                     $urandom, $urandom, $urandom, $urandom);
        end
      end else if (kind < 80) begin
        // a burst of fresh pairs that may fill the table, then misses and hits on those pairs
        fill_first.delete();
        fill_second.delete();
        burst_len = $urandom_range(75, 60);
        for (int n = 0; n < burst_len; n++) begin
          a = $urandom;
          b = $urandom;
          fill_first  = {fill_first, a};
          fill_second = {fill_second, b};
          op = ($urandom_range(4) == 0) ? spct_pkg::FUNC_GET : spct_pkg::FUNC_SET;
          offer_item(op, a, b, $urandom, $urandom, $urandom, $urandom);
        end
        for (int n = 0; n < 16; n++) begin
          pick = $urandom_range(fill_first.size() - 1);
          op   = $urandom_range(1) ? spct_pkg::FUNC_GET : spct_pkg::FUNC_SET;
          if ($urandom_range(2) == 0) begin
            offer_item(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          end else if ($urandom_range(1)) begin
            offer_item(op, fill_second[pick], fill_first[pick],
                       $urandom, $urandom, $urandom, $urandom);
          end else begin
            offer_item(op, fill_first[pick], fill_second[pick],
                       $urandom, $urandom, $urandom, $urandom);
          end
        end
      end else begin
        // noise: any code, unrelated ids
        burst_len = $urandom_range(15, 5);
        for (int n = 0; n < burst_len; n++) begin
          offer_item(2'($urandom_range(3)), pick_id(), pick_id(),
                     $urandom, $urandom, $urandom, $urandom);
        end
      end
    end
    in_valid <= 1'b0;

    // one edge first so the last accepted item is already counted as outstanding
    @(posedge clk);
    while (replies_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** symmetric_pair_cache_table_top: PASSED **");
    end else begin
      $display("** symmetric_pair_cache_table_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
src/spct_pkg.sv
src/spct_pair_cmp.sv
src/symmetric_pair_cache_table_top.sv
tb/sv/spct_pair_table_checker.sv
tb/sv/symmetric_pair_cache_table_top_tb.sv
